// ===== src/prta_pkg.sv =====
package prta_pkg;

  localparam int FIELD_W           = 52;
  localparam int ADDR_W            = FIELD_W + 2;
  localparam int PAGE_BYTES        = 4096;
  localparam int PAGE_LOG2         = $clog2(PAGE_BYTES);
  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int CFG_IDX_W         = 1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = CFG_IDX_W'(1);

  typedef struct packed {
    logic               mode;
    logic [FIELD_W-1:0] request_size;
    logic [FIELD_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic               success;
    logic [FIELD_W-1:0] block_address;
    logic [FIELD_W-1:0] scrub_start;
    logic [FIELD_W-1:0] scrub_length;
  } out_item_t;

  typedef struct packed {
    logic               used;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] base;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_ROUND,
    ST_PLACE,
    ST_FCHK
  } state_t;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic sum_add;
    logic round;
    logic hit_cap;
    logic clear_wr;
    logic place_wr;
    logic free_wr;
    logic respond;
    logic ok;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode;
    logic used;
    logic base_hit;
    logic last;
    logic req_zero;
    logic len_zero;
    logic out_range;
    logic too_big;
    logic size_bad;
  } dp_status_t;

endpackage

// ===== src/prta_ram.sv =====
module prta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/prta_ctrl.sv =====
module prta_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   cfg_we,
  input  prta_pkg::dp_status_t   status,
  output prta_pkg::ctrl_cmd_t    cmd,
  output logic                   busy
);

  prta_pkg::state_t state_r;
  prta_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prta_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      prta_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = prta_pkg::ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      prta_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = prta_pkg::ST_SETUP;
        end
      end
      prta_pkg::ST_SETUP: begin
        if (status.mode == prta_pkg::MODE_ALLOC) begin
          if (status.req_zero || status.len_zero) begin
            cmd.respond = 1'b1;
            state_nxt   = prta_pkg::ST_IDLE;
          end else begin
            state_nxt = prta_pkg::ST_WALK;
          end
        end else begin
          if (status.out_range) begin
            cmd.respond = 1'b1;
            state_nxt   = prta_pkg::ST_IDLE;
          end else begin
            state_nxt = prta_pkg::ST_WALK;
          end
        end
      end
      prta_pkg::ST_WALK: begin
        if (status.mode == prta_pkg::MODE_ALLOC) begin
          if (!status.used) begin
            state_nxt = prta_pkg::ST_ROUND;
          end else begin
            cmd.sum_add = 1'b1;
            if (status.last) begin
              cmd.respond = 1'b1;
              state_nxt   = prta_pkg::ST_IDLE;
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
        end else begin
          if (status.used && status.base_hit) begin
            cmd.hit_cap = 1'b1;
            state_nxt   = prta_pkg::ST_FCHK;
          end else if (status.last) begin
            cmd.respond = 1'b1;
            state_nxt   = prta_pkg::ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      prta_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = prta_pkg::ST_PLACE;
      end
      prta_pkg::ST_PLACE: begin
        cmd.respond = 1'b1;
        state_nxt   = prta_pkg::ST_IDLE;
        if (!status.too_big) begin
          cmd.place_wr = 1'b1;
          cmd.ok       = 1'b1;
        end
      end
      prta_pkg::ST_FCHK: begin
        cmd.respond = 1'b1;
        state_nxt   = prta_pkg::ST_IDLE;
        if (!status.size_bad) begin
          cmd.free_wr = 1'b1;
          cmd.ok      = 1'b1;
        end
      end
      default: begin
        state_nxt = prta_pkg::ST_CLEAR;
        cmd.idx_clr = 1'b1;
      end
    endcase
    if (cfg_we) begin
      cmd.idx_clr = 1'b1;
      state_nxt   = prta_pkg::ST_CLEAR;
    end
  end

  assign busy = (state_r != prta_pkg::ST_IDLE);

endmodule

// ===== src/prta_dp.sv =====
module prta_dp #(
  parameter int TABLE_ENTRIES = prta_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  prta_pkg::in_item_t                         in_data,
  input  logic                                       cfg_we,
  input  logic [prta_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [prta_pkg::FIELD_W-1:0]               cfg_wdata,
  input  prta_pkg::ctrl_cmd_t                        cmd,
  output prta_pkg::dp_status_t                       status,
  output logic                                       out_valid,
  output prta_pkg::out_item_t                        out_data
);

  localparam int FW = prta_pkg::FIELD_W;
  localparam int AW = prta_pkg::ADDR_W;
  localparam int PL = prta_pkg::PAGE_LOG2;
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SW = AW + IW;
  localparam int EW = $bits(prta_pkg::entry_t);

  localparam logic [AW-1:0] PMASK_A = AW'(prta_pkg::PAGE_BYTES - 1);
  localparam logic [SW-1:0] PMASK_S = SW'(prta_pkg::PAGE_BYTES - 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  logic [AW-1:0]       start_r;
  logic [AW-1:0]       len_r;
  logic [AW-1:0]       end_r;
  logic                mode_r;
  logic [AW-1:0]       need_r;
  logic [FW-1:0]       faddr_r;
  logic [IW-1:0]       idx_r;
  logic [SW-1:0]       sum_r;
  logic [SW-1:0]       sum_up_r;
  logic [PL-1:0]       gap_r;
  logic [FW-1:0]       hit_size_r;
  logic                out_valid_r;
  prta_pkg::out_item_t out_r;

  prta_pkg::entry_t    rd_entry;
  prta_pkg::entry_t    wr_entry;
  logic [EW-1:0]       rd_word;
  logic [IW-1:0]       idx_next;
  logic [IW-1:0]       rd_addr;
  logic                last;
  logic [AW-1:0]       faddr_ext;
  logic [SW-1:0]       total;
  logic [FW-1:0]       aligned;
  logic [FW-1:0]       new_size;
  logic [AW-1:0]       hit_end;
  prta_pkg::out_item_t out_nxt;

  assign last     = (idx_r == LAST_IDX);
  assign idx_next = last ? '0 : idx_r + 1'b1;
  assign rd_addr  = cmd.idx_inc ? idx_next : idx_r;
  assign rd_entry = prta_pkg::entry_t'(rd_word);

  assign faddr_ext = AW'(faddr_r);
  assign total     = sum_up_r + SW'(need_r);
  assign aligned   = start_r[FW-1:0] + sum_up_r[FW-1:0];
  assign new_size  = need_r[FW-1:0] + FW'(gap_r);
  assign hit_end   = faddr_ext + AW'(hit_size_r);

  always_comb begin
    wr_entry = '0;
    if (cmd.place_wr) begin
      wr_entry.used = 1'b1;
      wr_entry.size = new_size;
      wr_entry.base = aligned;
    end
  end

  prta_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.clear_wr | cmd.place_wr | cmd.free_wr),
    .waddr (idx_r),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      len_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prta_pkg::CFG_REGION_START:  start_r <= (AW'(cfg_wdata) + PMASK_A) & ~PMASK_A;
        prta_pkg::CFG_REGION_LENGTH: len_r   <= AW'(cfg_wdata) & ~PMASK_A;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    end_r <= start_r + len_r;
    if (cmd.load) begin
      mode_r  <= in_data.mode;
      need_r  <= (AW'(in_data.request_size) + PMASK_A) & ~PMASK_A;
      faddr_r <= in_data.free_address;
      sum_r   <= '0;
    end else if (cmd.sum_add) begin
      sum_r <= sum_r + SW'(rd_entry.size);
    end
    if (cmd.round) begin
      sum_up_r <= (sum_r + PMASK_S) & ~PMASK_S;
      gap_r    <= PL'(0) - sum_r[PL-1:0];
    end
    if (cmd.hit_cap) begin
      hit_size_r <= rd_entry.size;
    end
  end

  always_comb begin
    out_nxt = '0;
    if (cmd.ok) begin
      out_nxt.success = 1'b1;
      if (mode_r == prta_pkg::MODE_ALLOC) begin
        out_nxt.block_address = aligned;
      end else begin
        out_nxt.scrub_start  = faddr_r;
        out_nxt.scrub_length = hit_size_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_r <= out_nxt;
    end
  end

  assign status.mode      = mode_r;
  assign status.used      = rd_entry.used;
  assign status.base_hit  = (rd_entry.base == faddr_r);
  assign status.last      = last;
  assign status.req_zero  = (need_r == '0);
  assign status.len_zero  = (len_r == '0);
  assign status.out_range = (faddr_ext < start_r) || (faddr_ext >= end_r);
  assign status.too_big   = (total > SW'(len_r));
  assign status.size_bad  = (hit_size_r == '0) || (hit_end > end_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/page_region_table_allocator.sv =====
// Channel  Ports                                   Transfer
// input    start, busy, in_data                    beat when start && !busy
// result   out_valid, out_data                     beat on each out_valid cycle
// config   cfg_we, cfg_index, cfg_wdata            write when cfg_we
//
// Allocate: setup, walk to the first free entry, round, place. Free: setup,
// walk to the matching base, size check. A walk that finds nothing answers
// at the last entry; early rejects answer from setup. The walk reads one
// table entry per cycle through one port. After reset and after every config
// write the table is cleared, busy high. out_valid lasts one cycle; no stall.
module page_region_table_allocator #(
  parameter int TABLE_ENTRIES = prta_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  prta_pkg::in_item_t             in_data,
  output logic                           out_valid,
  output prta_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [prta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prta_pkg::FIELD_W-1:0]   cfg_wdata
);

  prta_pkg::ctrl_cmd_t  cmd;
  prta_pkg::dp_status_t status;

  prta_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cfg_we (cfg_we),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  prta_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== src/prta_checker.sv =====
module prta_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input prta_pkg::out_item_t            out_data
);

  localparam int PL = prta_pkg::PAGE_LOG2;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without prior work");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beats back to back");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.success |->
      out_data.block_address == '0 && out_data.scrub_start == '0 &&
      out_data.scrub_length == '0)
    else $error("failed result carries nonzero fields");

  a_page_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.success |->
      out_data.block_address[PL-1:0] == '0 && out_data.scrub_start[PL-1:0] == '0)
    else $error("result address not page aligned");

endmodule

bind page_region_table_allocator prta_checker u_prta_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
